FILE: design/lfu_cache_policy_defines.svh
// Assertion macros for the LFU cache policy block.
// Included by design files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef LFU_CACHE_POLICY_DEFINES_SVH
`define LFU_CACHE_POLICY_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check that is switched off while reset is asserted.
`define LFU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that also looks at the reset cycles themselves.
`define LFU_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LFU_ASSERT(lbl, prop, msg)
`define LFU_ASSERT_RST(lbl, prop, msg)
`endif

`endif

FILE: design/lfu_pkg.sv
// Shared types and constants for the LFU cache policy block.
// Depends on nothing; used by lfu_cache_policy and the testbench.
package lfu_pkg;

  // Width of the access stamps and of the access clock.
  localparam int STAMP_W = 48;
  // Width of the capacity register.
  localparam int CAP_W = 5;
  // Capacity after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Operation codes carried in the mode field.
  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  // One input word: an access request.
  typedef struct packed {
    logic               mode;
    logic signed [31:0] lookup_key;
    logic signed [31:0] store_value;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_value;
    logic               evicted;
    logic signed [31:0] evicted_key;
  } out_word_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } lfu_state_t;

endpackage

FILE: design/lfu_cache_policy.sv
// Top level of the LFU cache policy block: entry memory, scan sequencer and output register.
// Depends on lfu_pkg and on lfu_cache_policy_defines.svh for its checks.
//
// Usage: a key-value cache with least-frequently-used replacement, oldest access among
// equal counts. Requests enter on in_valid/in_ready as an lfu_pkg::in_word_t word (get or
// put); one result word per request leaves on out_valid/out_ready. cfg_valid/cfg_ready
// write the capacity register; write it only while no request is in flight.
// Each request scans all ENTRIES slots of the entry memory (one write port, one registered
// read port), one slot per cycle, looking for the key, the first free slot and the victim.
// A write-back state then updates the touched slot, and a done state loads the result.
// A new request is accepted only once the previous one has left the done state, so the
// memory scan sets the request rate.
// The next request is accepted while the previous result still waits in the output
// register; if the receiver stalls longer, the finished request holds before loading.
// Reset (synchronous, active low) clears all slot valid bits, the access clock, the
// output valid flag and sets the capacity to 16. No clearing pass is needed: the
// memory contents are only read for valid slots.
`include "lfu_cache_policy_defines.svh"

module lfu_cache_policy #(
  parameter int ENTRIES     = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  // Request channel
  input  logic                in_valid,
  output logic                in_ready,
  input  lfu_pkg::in_word_t   in_data,
  // Result channel
  output logic                out_valid,
  input  logic                out_ready,
  output lfu_pkg::out_word_t  out_data,
  // Capacity register write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [lfu_pkg::CAP_W-1:0] cfg_data
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > lfu_pkg::CAP_W) ? CNT_W : lfu_pkg::CAP_W;
  localparam logic [IDX_W:0]   ENTRIES_C = (IDX_W + 1)'(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(ENTRIES - 1);
  localparam logic [CMP_W-1:0] ENTRIES_W = CMP_W'(ENTRIES);

  // Contents of one memory slot.
  typedef struct packed {
    logic [31:0]                  key;
    logic [31:0]                  value;
    logic [COUNT_WIDTH-1:0]       count;
    logic [lfu_pkg::STAMP_W-1:0]  stamp;
  } ent_t;

  // Control registers
  lfu_pkg::lfu_state_t           state_r, state_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [ENTRIES-1:0]            valid_r, valid_nxt;
  logic [lfu_pkg::CAP_W-1:0]     capacity_r, capacity_nxt;
  logic [lfu_pkg::STAMP_W-1:0]   stamp_clk_r, stamp_clk_nxt;
  logic [IDX_W:0]                iss_r, iss_nxt;
  logic                          chk_vld_r, chk_vld_nxt;

  // Payload and scan registers
  lfu_pkg::out_word_t            out_data_r, out_data_nxt;
  lfu_pkg::out_word_t            res_r, res_nxt;
  lfu_pkg::in_word_t             item_r, item_nxt;
  logic [IDX_W-1:0]              chk_idx_r, chk_idx_nxt;
  logic [CNT_W-1:0]              used_r, used_nxt;
  logic                          found_r, found_nxt;
  logic [IDX_W-1:0]              found_idx_r, found_idx_nxt;
  logic [31:0]                   found_val_r, found_val_nxt;
  logic [COUNT_WIDTH-1:0]        found_cnt_r, found_cnt_nxt;
  logic                          free_found_r, free_found_nxt;
  logic [IDX_W-1:0]              free_idx_r, free_idx_nxt;
  logic                          vic_found_r, vic_found_nxt;
  logic [IDX_W-1:0]              vic_idx_r, vic_idx_nxt;
  logic [COUNT_WIDTH-1:0]        vic_cnt_r, vic_cnt_nxt;
  logic [lfu_pkg::STAMP_W-1:0]   vic_age_r, vic_age_nxt;
  logic [31:0]                   vic_key_r, vic_key_nxt;

  // Entry memory
  ent_t                          mem [ENTRIES];
  ent_t                          rd_ent_r;
  logic [IDX_W-1:0]              rd_idx;
  logic                          mem_we;
  logic [IDX_W-1:0]              wr_idx;
  ent_t                          wr_ent;

  // Effective capacity and occupancy at compare width
  logic [CMP_W-1:0]              cap_eff;
  logic [CMP_W-1:0]              used_ext;
  logic [lfu_pkg::STAMP_W-1:0]   age;
  logic                          chk_slot_vld;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign rd_idx    = iss_r[IDX_W-1:0];

  assign cap_eff = (CMP_W'(capacity_r) > ENTRIES_W) ? ENTRIES_W : CMP_W'(capacity_r);
  assign used_ext     = CMP_W'(used_r);
  assign age          = stamp_clk_r - rd_ent_r.stamp;
  assign chk_slot_vld = valid_r[chk_idx_r];

  // Capacity register
  always_comb begin
    capacity_nxt = capacity_r;
    if (cfg_valid) begin
      capacity_nxt = cfg_data;
    end
  end

  // Sequencer: next state, scan bookkeeping and write-back decision
  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    res_nxt        = res_r;
    item_nxt       = item_r;
    valid_nxt      = valid_r;
    stamp_clk_nxt  = stamp_clk_r;
    iss_nxt        = iss_r;
    chk_vld_nxt    = chk_vld_r;
    chk_idx_nxt    = chk_idx_r;
    used_nxt       = used_r;
    found_nxt      = found_r;
    found_idx_nxt  = found_idx_r;
    found_val_nxt  = found_val_r;
    found_cnt_nxt  = found_cnt_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    vic_found_nxt  = vic_found_r;
    vic_idx_nxt    = vic_idx_r;
    vic_cnt_nxt    = vic_cnt_r;
    vic_age_nxt    = vic_age_r;
    vic_key_nxt    = vic_key_r;
    in_ready       = 1'b0;
    mem_we         = 1'b0;
    wr_idx         = '0;
    wr_ent         = '0;

    // The receiver takes the waiting result word.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      lfu_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_nxt       = in_data;
          iss_nxt        = '0;
          chk_vld_nxt    = 1'b0;
          used_nxt       = '0;
          found_nxt      = 1'b0;
          free_found_nxt = 1'b0;
          vic_found_nxt  = 1'b0;
          state_nxt      = lfu_pkg::ST_SCAN;
        end
      end

      lfu_pkg::ST_SCAN: begin
        // Issue the next slot read.
        if (iss_r < ENTRIES_C) begin
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = iss_r[IDX_W-1:0];
          iss_nxt     = iss_r + 1'b1;
        end else begin
          chk_vld_nxt = 1'b0;
        end
        // Examine the slot whose data arrived this cycle.
        if (chk_vld_r) begin
          if (chk_slot_vld) begin
            used_nxt = used_r + 1'b1;
            if (rd_ent_r.key == item_r.lookup_key) begin
              found_nxt     = 1'b1;
              found_idx_nxt = chk_idx_r;
              found_val_nxt = rd_ent_r.value;
              found_cnt_nxt = rd_ent_r.count;
            end
            // Lowest count wins; among equal counts the oldest access wins.
            if (!vic_found_r || (rd_ent_r.count < vic_cnt_r) ||
                ((rd_ent_r.count == vic_cnt_r) && (age > vic_age_r))) begin
              vic_found_nxt = 1'b1;
              vic_idx_nxt   = chk_idx_r;
              vic_cnt_nxt   = rd_ent_r.count;
              vic_age_nxt   = age;
              vic_key_nxt   = rd_ent_r.key;
            end
          end else if (!free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = chk_idx_r;
          end
          if (chk_idx_r == LAST_IDX) begin
            state_nxt = lfu_pkg::ST_WRITE;
          end
        end
      end

      lfu_pkg::ST_WRITE: begin
        res_nxt   = '0;
        state_nxt = lfu_pkg::ST_DONE;
        if (found_r) begin
          // Hit: raise count, stamp, take the put value; a put at capacity 0 writes nothing.
          res_nxt.hit  = 1'b1;
          wr_idx       = found_idx_r;
          wr_ent.key   = item_r.lookup_key;
          wr_ent.value = found_val_r;
          wr_ent.count = (&found_cnt_r) ? found_cnt_r : found_cnt_r + COUNT_WIDTH'(1);
          wr_ent.stamp = stamp_clk_r;
          if (item_r.mode == lfu_pkg::MODE_GET) begin
            res_nxt.read_value = found_val_r;
            mem_we             = 1'b1;
          end else if (cap_eff != '0) begin
            wr_ent.value = item_r.store_value;
            mem_we       = 1'b1;
          end
        end else if ((item_r.mode == lfu_pkg::MODE_PUT) && (cap_eff != '0)) begin
          // Miss on a put: insert, evicting first when the cache is full.
          wr_ent.key   = item_r.lookup_key;
          wr_ent.value = item_r.store_value;
          wr_ent.count = COUNT_WIDTH'(1);
          wr_ent.stamp = stamp_clk_r;
          if ((used_ext >= cap_eff) && vic_found_r) begin
            res_nxt.evicted     = 1'b1;
            res_nxt.evicted_key = vic_key_r;
            wr_idx              = vic_idx_r;
            mem_we              = 1'b1;
          end else if (free_found_r) begin
            wr_idx = free_idx_r;
            mem_we = 1'b1;
          end
        end
        if (mem_we) begin
          valid_nxt[wr_idx] = 1'b1;
          stamp_clk_nxt     = stamp_clk_r + 1'b1;
        end
      end

      lfu_pkg::ST_DONE: begin
        // Load the result once the output register is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = lfu_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = lfu_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lfu_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      capacity_r  <= lfu_pkg::CAP_RESET;
      stamp_clk_r <= '0;
      iss_r       <= '0;
      chk_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      valid_r     <= valid_nxt;
      capacity_r  <= capacity_nxt;
      stamp_clk_r <= stamp_clk_nxt;
      iss_r       <= iss_nxt;
      chk_vld_r   <= chk_vld_nxt;
    end
  end

  // Payload and scan registers
  always_ff @(posedge clk) begin
    out_data_r   <= out_data_nxt;
    res_r        <= res_nxt;
    item_r       <= item_nxt;
    chk_idx_r    <= chk_idx_nxt;
    used_r       <= used_nxt;
    found_r      <= found_nxt;
    found_idx_r  <= found_idx_nxt;
    found_val_r  <= found_val_nxt;
    found_cnt_r  <= found_cnt_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    vic_found_r  <= vic_found_nxt;
    vic_idx_r    <= vic_idx_nxt;
    vic_cnt_r    <= vic_cnt_nxt;
    vic_age_r    <= vic_age_nxt;
    vic_key_r    <= vic_key_nxt;
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx] <= wr_ent;
    end
    rd_ent_r <= mem[rd_idx];
  end

  // Checks on the sequencer
  `LFU_ASSERT(a_accept_leaves_idle, in_valid && in_ready |=> state_r == lfu_pkg::ST_SCAN, "accepted word did not start a scan")
  `LFU_ASSERT(a_write_only_in_wb, mem_we |-> state_r == lfu_pkg::ST_WRITE, "memory written outside write-back")
  `LFU_ASSERT(a_result_from_done, $rose(out_valid_r) |-> $past(state_r) == lfu_pkg::ST_DONE, "result loaded outside done state")
  `LFU_ASSERT(a_clock_step, (stamp_clk_r != $past(stamp_clk_r)) && $past(rst_n) |-> $past(state_r) == lfu_pkg::ST_WRITE && stamp_clk_r == $past(stamp_clk_r) + 1'b1, "access clock moved outside write-back")
  `LFU_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid_r && state_r == lfu_pkg::ST_IDLE && valid_r == '0, "reset left state behind")

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for lfu_cache_policy: directed table, then random gets and puts.
// Depends on lfu_pkg and the lfu_cache_policy RTL; a built-in cache predictor checks each word.

module tb;

  localparam int SLOTS           = 16;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int RANDOM_SEGMENTS = 12;
  localparam int SEGMENT_WORDS   = 50;
  localparam int DRAIN_CYCLES    = SLOTS + 8;
  localparam int POOL_SIZE       = 20;
  localparam int REPLY_DEPTH     = 1024;
  localparam logic [15:0] COUNT_TOP = 16'hFFFF;
  localparam lfu_pkg::out_word_t NO_HIT = '0;

  // One row of the directed table: either a capacity write or a request word.
  typedef struct packed {
    logic                      is_cfg;
    logic [lfu_pkg::CAP_W-1:0] cap;
    lfu_pkg::in_word_t         req;
    logic                      typed;
    lfu_pkg::out_word_t        want;
  } dir_row_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  lfu_pkg::in_word_t           in_data = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  lfu_pkg::out_word_t          out_data;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [lfu_pkg::CAP_W-1:0]   cfg_data = '0;

  int                          send_idle_pct;
  int                          recv_idle_pct;
  int                          mismatches = 0;
  int                          cycle_count = 0;
  // Expected reply words, oldest at reply_head.
  lfu_pkg::out_word_t          awaited_replies [REPLY_DEPTH];
  int                          reply_head = 0;
  int                          reply_tail = 0;
  lfu_pkg::out_word_t          head_reply;
  dir_row_t                    dir_rows [0:23];

  // Predictor copy of the cache contents and the capacity register.
  logic [lfu_pkg::CAP_W-1:0]   cap_reg;
  bit                          slot_used  [SLOTS];
  logic [31:0]                 slot_key   [SLOTS];
  logic [31:0]                 slot_value [SLOTS];
  logic [15:0]                 slot_count [SLOTS];
  logic [lfu_pkg::STAMP_W-1:0] slot_stamp [SLOTS];
  logic [lfu_pkg::STAMP_W-1:0] access_clock;

  lfu_cache_policy DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Stamp a slot with the access clock, which wraps at its width.
  function automatic void touch_slot(int s);
    slot_stamp[s] = access_clock;
    access_clock  = access_clock + 1'b1;
  endfunction

  // A hit raises the use count, saturating, and makes the slot the most recent.
  function automatic void bump_slot(int s);
    if (slot_count[s] < COUNT_TOP) slot_count[s] = slot_count[s] + 1'b1;
    touch_slot(s);
  endfunction

  // Apply one get or put to the predicted cache and return the reply word it gives.
  function automatic lfu_pkg::out_word_t cache_access(lfu_pkg::in_word_t w);
    lfu_pkg::out_word_t          r;
    int                          lim;
    int                          hit_slot;
    int                          free_slot;
    int                          victim;
    int                          used;
    logic [lfu_pkg::STAMP_W-1:0] age;
    logic [lfu_pkg::STAMP_W-1:0] best_age;
    r         = '0;
    lim       = (cap_reg > SLOTS) ? SLOTS : int'(cap_reg);
    hit_slot  = -1;
    free_slot = -1;
    victim    = -1;
    used      = 0;
    best_age  = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[i]) begin
        used++;
        if (slot_key[i] == w.lookup_key) hit_slot = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (hit_slot >= 0) begin
      r.hit = 1'b1;
      if (w.mode == lfu_pkg::MODE_GET) begin
        r.read_value = slot_value[hit_slot];
        bump_slot(hit_slot);
      end else if (lim != 0) begin
        slot_value[hit_slot] = w.store_value;
        bump_slot(hit_slot);
      end
      return r;
    end
    if (w.mode == lfu_pkg::MODE_GET || lim == 0) return r;
    // Full: evict the lowest count, oldest access among equal counts.
    if (used >= lim) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_used[i]) begin
          age = access_clock - slot_stamp[i];
          if (victim < 0 || slot_count[i] < slot_count[victim] ||
              (slot_count[i] == slot_count[victim] && age > best_age)) begin
            victim   = i;
            best_age = age;
          end
        end
      end
      if (victim >= 0) begin
        r.evicted         = 1'b1;
        r.evicted_key     = slot_key[victim];
        slot_used[victim] = 1'b0;
        free_slot         = victim;
      end
    end
    if (free_slot >= 0) begin
      slot_used[free_slot]  = 1'b1;
      slot_key[free_slot]   = w.lookup_key;
      slot_value[free_slot] = w.store_value;
      slot_count[free_slot] = 16'd1;
      touch_slot(free_slot);
    end
    return r;
  endfunction

  function automatic lfu_pkg::out_word_t reply(logic h, logic [31:0] rv, logic ev,
                                               logic [31:0] ek);
    lfu_pkg::out_word_t r;
    r.hit         = h;
    r.read_value  = rv;
    r.evicted     = ev;
    r.evicted_key = ek;
    return r;
  endfunction

  // Request row whose reply comes from the predictor.
  function automatic dir_row_t req_row(logic m, logic [31:0] k, logic [31:0] v);
    dir_row_t r;
    r                   = '0;
    r.req.mode          = m;
    r.req.lookup_key    = k;
    r.req.store_value   = v;
    return r;
  endfunction

  // Request row with the reply typed in.
  function automatic dir_row_t checked_row(logic m, logic [31:0] k, logic [31:0] v,
                                           lfu_pkg::out_word_t want);
    dir_row_t r;
    r       = req_row(m, k, v);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic dir_row_t cap_row(logic [lfu_pkg::CAP_W-1:0] c);
    dir_row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.cap    = c;
    return r;
  endfunction

  // Offer one request word, with random idle cycles ahead of it; called and returns at negedge.
  task automatic send_request(lfu_pkg::in_word_t w, logic typed, lfu_pkg::out_word_t want);
    lfu_pkg::out_word_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = cache_access(w);
    awaited_replies[reply_tail % REPLY_DEPTH] = typed ? want : predicted;
    reply_tail++;
    @(negedge clk);
  endtask

  // Write the capacity register once every outstanding reply has come back.
  task automatic write_capacity(logic [lfu_pkg::CAP_W-1:0] c);
    in_valid <= 1'b0;
    while (reply_tail != reply_head) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= c;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cap_reg = c;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver side: stall at random.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Compare every accepted reply word with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (reply_tail == reply_head) begin
        $error("reply word with no request outstanding");
        mismatches++;
      end else begin
        head_reply = awaited_replies[reply_head % REPLY_DEPTH];
        reply_head++;
        if (out_data.hit !== head_reply.hit) begin
          $error("hit: expected %0d, got %0d", head_reply.hit, out_data.hit);
          mismatches++;
        end
        if (out_data.read_value !== head_reply.read_value) begin
          $error("read_value: expected %0h, got %0h", head_reply.read_value,
                 out_data.read_value);
          mismatches++;
        end
        if (out_data.evicted !== head_reply.evicted) begin
          $error("evicted: expected %0d, got %0d", head_reply.evicted, out_data.evicted);
          mismatches++;
        end
        if (out_data.evicted_key !== head_reply.evicted_key) begin
          $error("evicted_key: expected %0h, got %0h", head_reply.evicted_key,
                 out_data.evicted_key);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [31:0]               key_pool [POOL_SIZE];
    lfu_pkg::in_word_t         w;
    logic [lfu_pkg::CAP_W-1:0] c;
    cap_reg      = lfu_pkg::CAP_RESET;
    access_clock = '0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_used[i]  = 1'b0;
      slot_key[i]   = '0;
      slot_value[i] = '0;
      slot_count[i] = '0;
      slot_stamp[i] = '0;
    end
    send_idle_pct = 26;
    recv_idle_pct = 73;

    // Extremes of key and value, put hit, then lowered, zero and oversized capacity.
    dir_rows = '{
      checked_row(lfu_pkg::MODE_GET, 32'h0000_0000, 32'h0000_0000, NO_HIT),
      checked_row(lfu_pkg::MODE_PUT, 32'h7FFF_FFFF, 32'h8000_0000, NO_HIT),
      checked_row(lfu_pkg::MODE_GET, 32'h7FFF_FFFF, 32'h0000_0000,
                  reply(1'b1, 32'h8000_0000, 1'b0, 32'h0)),
      checked_row(lfu_pkg::MODE_PUT, 32'h8000_0000, 32'h7FFF_FFFF, NO_HIT),
      checked_row(lfu_pkg::MODE_GET, 32'h8000_0000, 32'hFFFF_FFFF,
                  reply(1'b1, 32'h7FFF_FFFF, 1'b0, 32'h0)),
      checked_row(lfu_pkg::MODE_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                  reply(1'b1, 32'h0, 1'b0, 32'h0)),
      checked_row(lfu_pkg::MODE_GET, 32'h7FFF_FFFF, 32'h0000_0000,
                  reply(1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0)),
      checked_row(lfu_pkg::MODE_PUT, 32'hFFFF_FFFF, 32'h0000_0000, NO_HIT),
      checked_row(lfu_pkg::MODE_PUT, 32'h0000_0000, 32'h0000_0001, NO_HIT),
      req_row(lfu_pkg::MODE_GET, 32'h0000_0000, 32'h0000_0000),
      cap_row(5'd2),
      req_row(lfu_pkg::MODE_PUT, 32'h1234_5678, 32'hA5A5_A5A5),
      req_row(lfu_pkg::MODE_PUT, 32'h5A5A_5A5A, 32'h0000_0005),
      req_row(lfu_pkg::MODE_GET, 32'h8000_0000, 32'h0000_0000),
      cap_row(5'd0),
      checked_row(lfu_pkg::MODE_PUT, 32'h8000_0000, 32'h1111_1111,
                  reply(1'b1, 32'h0, 1'b0, 32'h0)),
      checked_row(lfu_pkg::MODE_PUT, 32'h0BAD_F00D, 32'h0000_0001, NO_HIT),
      req_row(lfu_pkg::MODE_GET, 32'h8000_0000, 32'h0000_0000),
      checked_row(lfu_pkg::MODE_GET, 32'h0BAD_F00D, 32'h0000_0000, NO_HIT),
      cap_row(5'd31),
      req_row(lfu_pkg::MODE_PUT, 32'h0000_0001, 32'h0000_0002),
      req_row(lfu_pkg::MODE_PUT, 32'h0000_0002, 32'h0000_0003),
      cap_row(5'd1),
      req_row(lfu_pkg::MODE_PUT, 32'h0000_0003, 32'h0000_0004)
    };

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_capacity(dir_rows[i].cap);
      end else begin
        send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // A small key pool keeps hits and evictions frequent; some keys are fully random.
    foreach (key_pool[k]) key_pool[k] = $urandom;

    for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
      if (seg == RANDOM_SEGMENTS / 3) begin
        send_idle_pct = 73;
        recv_idle_pct = 26;
      end else if (seg == 2 * RANDOM_SEGMENTS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (seg)
        0:       c = 5'd16;
        1:       c = 5'd1;
        2:       c = 5'd0;
        3:       c = 5'd31;
        4:       c = 5'd3;
        default: c = lfu_pkg::CAP_W'($urandom_range(0, 31));
      endcase
      write_capacity(c);
      repeat (SEGMENT_WORDS) begin
        w.mode        = $urandom_range(0, 1) ? lfu_pkg::MODE_PUT : lfu_pkg::MODE_GET;
        w.lookup_key  = ($urandom_range(0, 99) < 85) ?
                        key_pool[$urandom_range(0, POOL_SIZE - 1)] : $urandom;
        w.store_value = $urandom;
        send_request(w, 1'b0, NO_HIT);
      end
    end

    in_valid <= 1'b0;
    while (reply_tail != reply_head) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/lfu_pkg.sv
design/lfu_cache_policy.sv
test/tb.sv
